### rtl/core/lfps_pkg.sv
package lfps_pkg;

   localparam int LFPS_FRAC_BITS = 8;
   localparam int LFPS_RUN_MAX   = 255;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_SPEED      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEER_GAIN      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLACK_LEVEL     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WHITE_LEVEL     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_LEVEL    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_LIMIT       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEGRAL_DECAY  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_DERIVATIVE_GAIN = 3'd7;

   localparam logic [6:0] RST_BASE_SPEED      = 7'd25;
   localparam logic [6:0] RST_STEER_GAIN      = 7'd12;
   localparam logic [6:0] RST_BLACK_LEVEL     = 7'd8;
   localparam logic [6:0] RST_WHITE_LEVEL     = 7'd40;
   localparam logic [6:0] RST_CENTER_LEVEL    = 7'd20;
   localparam logic [7:0] RST_RUN_LIMIT       = 8'd20;
   localparam logic [7:0] RST_INTEGRAL_DECAY  = 8'd205;
   localparam logic [7:0] RST_DERIVATIVE_GAIN = 8'd179;

   localparam logic [1:0] TURN_NONE  = 2'd0;
   localparam logic [1:0] TURN_BLACK = 2'd1;
   localparam logic [1:0] TURN_WHITE = 2'd2;

   // floor(n/3) = (n*171) >> 9 for n < 256
   localparam logic [15:0] THIRD_RECIP = 16'd171;
   localparam int          THIRD_SHIFT = 9;

   localparam int SUM_W = 12;
   localparam logic signed [SUM_W-1:0] SPEED_HI = 12'sd100;
   localparam logic signed [SUM_W-1:0] SPEED_LO = -12'sd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_DL,
      ST_MUL_DR,
      ST_SUM,
      ST_DONE
   } lfps_state_type;

   function automatic logic signed [7:0] sat_speed(input logic signed [SUM_W-1:0] v);
      logic signed [7:0] res;
      if (v > SPEED_HI) begin
         res = 8'sd100;
      end else if (v < SPEED_LO) begin
         res = -8'sd100;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

endpackage

### rtl/core/line_follower_pid_steering_top.sv
// channel  | direction | tdata                              | tuser
// req      | in        | [6:0] reflection, [7] zero         | -
// rsp      | out       | [7:0] left_speed, [15:8] right_speed | [1:0] hard_turn
// csr      | in        | csr_addr selects, csr_wdata [7:0]  | -
//
// Each sample runs a restoring divide, one quotient bit per cycle, then one
// shared multiplier serves the P, I and two D products in turn. A new sample
// is accepted only after the previous one has been committed. Samples with a
// zero or negative span, or a full deviation, skip the divide.
// reset is synchronous: registers to defaults, speed history to 25, runs and
// integral to zero. A result waits in the output register; the next sample is
// accepted meanwhile, and its commit holds until that result is taken.
module line_follower_pid_steering_top
   import lfps_pkg::*;
#(
   parameter int FRAC_BITS = LFPS_FRAC_BITS,
   parameter int RUN_MAX   = LFPS_RUN_MAX
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [6:0] reflection
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [7:0] left_speed, [15:8] right_speed
   output logic [1:0]            rsp_tuser,   // [1:0] hard_turn
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW    = FRAC_BITS + 1;
   localparam int ACC_W = FRAC_BITS + 8;
   localparam int MA_W  = FRAC_BITS + 8;
   localparam int PW    = MA_W + 8;
   localparam int CNT_W = $clog2(FRAC_BITS);
   localparam int RUN_W = $clog2(RUN_MAX + 1);
   localparam int CMP_W = (RUN_W > 8) ? RUN_W : 8;

   localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [RUN_W-1:0] RUN_TOP = RUN_W'(RUN_MAX);

   lfps_state_type state_ff, state_in;

   logic [6:0] base_ff, gain_ff, black_ff, white_ff, center_ff;
   logic [7:0] limit_ff, decay_ff, dgain_ff;

   logic [6:0]              r_ff, r_in;
   logic                    neg_ff, neg_in;
   logic [6:0]              span_ff, span_in;
   logic [6:0]              rem_ff, rem_in;
   logic [QW-1:0]           q_ff, q_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic signed [7:0]       p_ff, p_in;
   logic signed [8:0]       dl_ff, dl_in;
   logic signed [SUM_W-1:0] lraw_ff, lraw_in, rraw_ff, rraw_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [7:0]       last_l_ff, last_l_in, last_r_ff, last_r_in;
   logic signed [7:0]       prior_l_ff, prior_l_in, prior_r_ff, prior_r_in;
   logic [RUN_W-1:0]        brun_ff, brun_in, wrun_ff, wrun_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]       rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic [1:0]              rsp_turn_ff, rsp_turn_in;

   logic [MA_W-1:0] mul_a;
   logic [7:0]      mul_b;
   logic [PW-1:0]   mul_prod;

   logic [6:0]  refl, r_clamp, diff;
   logic        below, span_le0, div_ge;
   logic [7:0]  span_raw, rem2;
   logic signed [QW:0]      dev_s;
   logic signed [ACC_W:0]   acc_sum;
   logic [ACC_W-1:0]        acc_mag, acc_term_mag;
   logic signed [ACC_W-1:0] acc_sat;
   logic [6:0]  p_mag;
   logic [7:0]  i_mag;
   logic signed [8:0]  i_s;
   logic signed [8:0]  dlast_l, dlast_r;
   logic [8:0]  dmag_l, dmag_r;
   logic [7:0]  dterm_mag;
   logic signed [8:0]  dr_s;
   logic [15:0] tspd_prod;
   logic [6:0]  tspd;
   logic signed [SUM_W-1:0] tspd_s, base_s, left_sel, right_sel;
   logic        black_hit, white_hit, bturn, wturn;
   logic [RUN_W-1:0] brun_nx, wrun_nx;
   logic [1:0]  turn_sel;

   assign mul_prod = PW'(mul_a) * PW'(mul_b);

   assign refl    = req_tdata[6:0];
   assign r_clamp = (refl < black_ff) ? black_ff : ((refl > white_ff) ? white_ff : refl);

   assign below    = r_ff < center_ff;
   assign diff     = below ? (center_ff - r_ff) : (r_ff - center_ff);
   assign span_raw = below ? ({1'b0, center_ff} - {1'b0, black_ff})
                           : ({1'b0, white_ff} - {1'b0, center_ff});
   assign span_le0 = span_raw[7] || (span_raw == 8'd0);

   assign rem2   = {rem_ff, 1'b0};
   assign div_ge = rem2 >= {1'b0, span_ff};

   assign dev_s = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign p_mag = prod_ff[FRAC_BITS+6:FRAC_BITS];

   assign acc_mag      = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign acc_term_mag = prod_ff[ACC_W+7:8];
   assign acc_sum = (acc_ff[ACC_W-1] ? -$signed({1'b0, acc_term_mag})
                                     : $signed({1'b0, acc_term_mag}))
                    + $signed({{(ACC_W-QW-1){dev_s[QW]}}, dev_s});
   assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                    ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];
   assign i_mag = acc_mag[FRAC_BITS+7:FRAC_BITS];
   assign i_s   = acc_ff[ACC_W-1] ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});

   assign dlast_l   = 9'(last_l_ff) - 9'(prior_l_ff);
   assign dlast_r   = 9'(last_r_ff) - 9'(prior_r_ff);
   assign dmag_l    = dlast_l[8] ? 9'(-dlast_l) : dlast_l;
   assign dmag_r    = dlast_r[8] ? 9'(-dlast_r) : dlast_r;
   assign dterm_mag = prod_ff[15:8];
   assign dr_s      = dlast_r[8] ? -$signed({1'b0, dterm_mag}) : $signed({1'b0, dterm_mag});

   assign tspd_prod = 16'({base_ff, 1'b0}) * THIRD_RECIP;
   assign tspd      = tspd_prod[THIRD_SHIFT+6:THIRD_SHIFT];
   assign tspd_s    = $signed({{(SUM_W-7){1'b0}}, tspd});
   assign base_s    = $signed({{(SUM_W-7){1'b0}}, base_ff});

   assign black_hit = r_ff <= black_ff;
   assign white_hit = r_ff >= white_ff;
   assign brun_nx   = black_hit ? ((brun_ff < RUN_TOP) ? brun_ff + 1'b1 : RUN_TOP) : '0;
   assign wrun_nx   = white_hit ? ((wrun_ff < RUN_TOP) ? wrun_ff + 1'b1 : RUN_TOP) : '0;
   assign bturn     = CMP_W'(brun_nx) > CMP_W'(limit_ff);
   assign wturn     = CMP_W'(wrun_nx) > CMP_W'(limit_ff);

   always_comb begin
      if (wturn) begin
         left_sel  = -tspd_s;
         right_sel = base_s;
         turn_sel  = TURN_WHITE;
      end else if (bturn) begin
         left_sel  = tspd_s;
         right_sel = -tspd_s;
         turn_sel  = TURN_BLACK;
      end else begin
         left_sel  = lraw_ff;
         right_sel = rraw_ff;
         turn_sel  = TURN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      r_in         = r_ff;
      neg_in       = neg_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      dl_in        = dl_ff;
      lraw_in      = lraw_ff;
      rraw_in      = rraw_ff;
      acc_in       = acc_ff;
      last_l_in    = last_l_ff;
      last_r_in    = last_r_ff;
      prior_l_in   = prior_l_ff;
      prior_r_in   = prior_r_ff;
      brun_in      = brun_ff;
      wrun_in      = wrun_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_turn_in  = rsp_turn_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               r_in     = r_clamp;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_in  = below;
            span_in = span_raw[6:0];
            rem_in  = diff;
            q_in    = '0;
            cnt_in  = '0;
            if (span_le0) begin
               q_in     = (below || (diff != 7'd0)) ? ONE_Q : '0;
               state_in = ST_MUL_P;
            end else if (diff >= span_raw[6:0]) begin
               q_in     = ONE_Q;
               state_in = ST_MUL_P;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? 7'(rem2 - {1'b0, span_ff}) : rem2[6:0];
            q_in   = {q_ff[FRAC_BITS-1:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            mul_a    = MA_W'(q_ff);
            mul_b    = {1'b0, gain_ff};
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            p_in     = neg_ff ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
            mul_a    = acc_mag;
            mul_b    = decay_ff;
            state_in = ST_MUL_DL;
         end
         ST_MUL_DL: begin
            acc_in   = acc_sat;
            mul_a    = MA_W'(dmag_l[7:0]);
            mul_b    = dgain_ff;
            state_in = ST_MUL_DR;
         end
         ST_MUL_DR: begin
            dl_in    = dlast_l[8] ? -$signed({1'b0, dterm_mag}) : $signed({1'b0, dterm_mag});
            mul_a    = MA_W'(dmag_r[7:0]);
            mul_b    = dgain_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            lraw_in  = base_s - SUM_W'(p_ff) - SUM_W'(i_s) + SUM_W'(dl_ff);
            rraw_in  = base_s + SUM_W'(p_ff) + SUM_W'(i_s) + SUM_W'(dr_s);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               brun_in      = brun_nx;
               wrun_in      = wrun_nx;
               rsp_left_in  = sat_speed(left_sel);
               rsp_right_in = sat_speed(right_sel);
               rsp_turn_in  = turn_sel;
               rsp_valid_in = 1'b1;
               prior_l_in   = last_l_ff;
               prior_r_in   = last_r_ff;
               last_l_in    = sat_speed(left_sel);
               last_r_in    = sat_speed(right_sel);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= RST_BASE_SPEED;
         gain_ff      <= RST_STEER_GAIN;
         black_ff     <= RST_BLACK_LEVEL;
         white_ff     <= RST_WHITE_LEVEL;
         center_ff    <= RST_CENTER_LEVEL;
         limit_ff     <= RST_RUN_LIMIT;
         decay_ff     <= RST_INTEGRAL_DECAY;
         dgain_ff     <= RST_DERIVATIVE_GAIN;
         acc_ff       <= '0;
         last_l_ff    <= 8'(RST_BASE_SPEED);
         last_r_ff    <= 8'(RST_BASE_SPEED);
         prior_l_ff   <= 8'(RST_BASE_SPEED);
         prior_r_ff   <= 8'(RST_BASE_SPEED);
         brun_ff      <= '0;
         wrun_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_BASE_SPEED:      base_ff   <= csr_wdata[6:0];
               CSR_STEER_GAIN:      gain_ff   <= csr_wdata[6:0];
               CSR_BLACK_LEVEL:     black_ff  <= csr_wdata[6:0];
               CSR_WHITE_LEVEL:     white_ff  <= csr_wdata[6:0];
               CSR_CENTER_LEVEL:    center_ff <= csr_wdata[6:0];
               CSR_RUN_LIMIT:       limit_ff  <= csr_wdata;
               CSR_INTEGRAL_DECAY:  decay_ff  <= csr_wdata;
               CSR_DERIVATIVE_GAIN: dgain_ff  <= csr_wdata;
               default: ;
            endcase
         end
         acc_ff       <= acc_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
         prior_l_ff   <= prior_l_in;
         prior_r_ff   <= prior_r_in;
         brun_ff      <= brun_in;
         wrun_ff      <= wrun_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      neg_ff       <= neg_in;
      span_ff      <= span_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      prod_ff      <= prod_in;
      p_ff         <= p_in;
      dl_ff        <= dl_in;
      lraw_ff      <= lraw_in;
      rraw_ff      <= rraw_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_turn_ff  <= rsp_turn_in;
   end

   assign prod_in = mul_prod;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_right_ff, rsp_left_ff};
   assign rsp_tuser  = rsp_turn_ff;

`ifndef SYNTHESIS
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("committed result not presented");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_P) |-> (q_ff <= ONE_Q))
      else $error("deviation magnitude above one");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_left_ff >= -8'sd100 && rsp_left_ff <= 8'sd100 &&
                      rsp_right_ff >= -8'sd100 && rsp_right_ff <= 8'sd100))
      else $error("speed out of range");

   a_black_turn: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == TURN_BLACK) |-> (rsp_left_ff == -rsp_right_ff))
      else $error("black-run turn not symmetric");

   a_history: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (last_l_ff == rsp_left_ff && last_r_ff == rsp_right_ff))
      else $error("speed history not tracking output");
`endif

endmodule
